/* hw/rtl/ekd_pkg.sv */
package ekd_pkg;

    localparam int VALUE_W   = 11;
    localparam int TARGET_W  = 11;
    localparam int BUDGET_W  = 12;
    localparam int TOTAL_W   = 20;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // reciprocal precision for the slot reduction
    localparam int RECIP_W = 24;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic load;
        logic advance;
    } slot_ctrl_t;

endpackage

/* hw/rtl/ekd_ram.sv */
module ekd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ekd_slot.sv */
module ekd_slot
    import ekd_pkg::*;
#(
    parameter int VALUE_MAX = 1024
) (
    input  logic                         clk,
    input  slot_ctrl_t                   ctrl,
    input  logic [VALUE_W-1:0]           value,
    output logic [$clog2(VALUE_MAX)-1:0] slot
);

    localparam int SW      = $clog2(VALUE_MAX);
    localparam int CONST_W = $clog2(VALUE_MAX + 1);
    localparam int P1_W    = VALUE_W + RECIP_W;
    localparam int P2_W    = VALUE_W + CONST_W;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((1 << RECIP_W) / VALUE_MAX);
    localparam logic [P2_W-1:0]    VM_W      = P2_W'(VALUE_MAX);
    localparam logic [SW-1:0]      SLOT_LAST = SW'(VALUE_MAX - 1);

    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] q_reg;
    logic               zero_reg;
    logic [SW-1:0]      slot_reg;

    logic [VALUE_W-1:0] x;
    logic [P1_W-1:0]    prod1;
    logic [P2_W-1:0]    prod2;
    logic [VALUE_W-1:0] rem;
    logic [P2_W-1:0]    rem_wide;
    logic [P2_W-1:0]    rem_fixed;

    // quotient estimate is exact or one low, so one correction suffices
    assign x         = value - 1'b1;
    assign prod1     = P1_W'(x) * P1_W'(RECIP);
    assign prod2     = P2_W'(q_reg) * VM_W;
    assign rem       = x_reg - prod2[VALUE_W-1:0];
    assign rem_wide  = P2_W'(rem);
    assign rem_fixed = (rem_wide >= VM_W) ? rem_wide - VM_W : rem_wide;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg    <= x;
            q_reg    <= prod1[P1_W-1:RECIP_W];
            zero_reg <= (value == '0);
        end
        if (ctrl.advance)
        begin
            // value zero aliases the top slot
            slot_reg <= zero_reg ? SLOT_LAST : SW'(rem_fixed);
        end
    end

    assign slot = slot_reg;

endmodule

/* hw/rtl/exact_k_distinct_window_count_core.sv */
// Counts, over a stream of values, the contiguous subarrays that hold exactly
// k distinct values, and returns the running count after every input item.
// Input transaction: s_tdata carries the value, s_tuser the start-of-sequence
// flag. Output transaction: m_tdata carries the running total, m_tuser flags
// an item ignored because the sequence already holds MAX_LEN elements.
// The cfg channel writes k; it is always ready and applies at the next start.
// An item passes through S_MOD, S_CHECK and S_INC to a result while the
// distinct budget stays positive; an ignored item ends in S_CHECK; otherwise
// S_CREAD and S_DEC repeat for every element that leaves the left end of the
// window; each such step is a history read followed by a count-memory read.
// s_tready returns with the result, so no new item is accepted until the
// previous item's result is produced. A start-of-sequence item first passes
// S_DRAIN, which walks the elements still in the window to zero their counts.
// After reset the count memory is cleared with s_tready low; the block then
// behaves as an empty sequence.
// Results sit in an output register: the next item is accepted while one
// waits, and a second finished result is held until m_tready frees the
// register, during which no new item is accepted.
module exact_k_distinct_window_count_core
    import ekd_pkg::*;
#(
    parameter int MAX_LEN   = 1024,
    parameter int VALUE_MAX = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value[10:0], zero fill
    input  logic [0:0]           s_tuser,   // first
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // running_total[19:0], zero fill
    output logic [0:0]           m_tuser,   // overflow
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TARGET_W-1:0]  cfg_data   // distinct_target
);

    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int SW = $clog2(VALUE_MAX);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(VALUE_MAX - 1);
    localparam logic [IW-1:0] LEN_LIMIT = IW'(MAX_LEN);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_DRAIN,
        S_CHECK,
        S_INC,
        S_CREAD,
        S_DEC,
        S_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [SW-1:0]               clr_addr_reg, clr_addr_next;
    logic [TARGET_W-1:0]         target_reg, target_next;
    logic                        first_reg, first_next;
    logic [IW-1:0]               left_reg, left_next;
    logic [IW-1:0]               right_reg, right_next;
    logic signed [BUDGET_W-1:0]  budget_reg, budget_next;
    logic [IW-1:0]               prefix_reg, prefix_next;
    logic [TOTAL_W-1:0]          total_reg, total_next;
    logic [IW-1:0]               dr_ptr_reg, dr_ptr_next;
    logic                        dr_pend_reg, dr_pend_next;
    logic                        trim_reg, trim_next;
    logic [SW-1:0]               drop_slot_reg, drop_slot_next;
    logic [TOTAL_W-1:0]          pend_total_reg, pend_total_next;
    logic                        pend_ovf_reg, pend_ovf_next;
    logic                        m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0]          m_total_reg, m_total_next;
    logic                        m_ovf_reg, m_ovf_next;

    logic              cnt_we;
    logic [SW-1:0]     cnt_waddr;
    logic [CW-1:0]     cnt_wdata;
    logic [SW-1:0]     cnt_raddr;
    logic [CW-1:0]     cnt_rdata;
    logic              hist_we;
    logic [AW-1:0]     hist_waddr;
    logic [SW-1:0]     hist_wdata;
    logic [AW-1:0]     hist_raddr;
    logic [SW-1:0]     hist_rdata;
    logic [SW-1:0]     slot;
    slot_ctrl_t        slot_ctrl;

    logic              out_free;
    logic              res_load;
    logic [TOTAL_W-1:0] res_total;
    logic              res_ovf;

    ekd_slot #(
        .VALUE_MAX(VALUE_MAX)
    ) u_slot (
        .clk  (clk),
        .ctrl (slot_ctrl),
        .value(s_tdata[VALUE_W-1:0]),
        .slot (slot)
    );

    ekd_ram #(
        .WIDTH(CW),
        .DEPTH(VALUE_MAX)
    ) u_count_ram (
        .clk  (clk),
        .we   (cnt_we),
        .waddr(cnt_waddr),
        .wdata(cnt_wdata),
        .raddr(cnt_raddr),
        .rdata(cnt_rdata)
    );

    ekd_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_LEN)
    ) u_hist_ram (
        .clk  (clk),
        .we   (hist_we),
        .waddr(hist_waddr),
        .wdata(hist_wdata),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - TOTAL_W){1'b0}}, m_total_reg};
    assign m_tuser   = m_ovf_reg;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        logic signed [BUDGET_W-1:0] budget_dec;
        logic [IW-1:0]              left_plus;
        logic [IW-1:0]              prefix_n;
        logic [TOTAL_W:0]           sum;
        logic                       drop;

        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        target_next     = target_reg;
        first_next      = first_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        budget_next     = budget_reg;
        prefix_next     = prefix_reg;
        total_next      = total_reg;
        dr_ptr_next     = dr_ptr_reg;
        dr_pend_next    = dr_pend_reg;
        trim_next       = trim_reg;
        drop_slot_next  = drop_slot_reg;
        pend_total_next = pend_total_reg;
        pend_ovf_next   = pend_ovf_reg;
        m_valid_next    = m_valid_reg;
        m_total_next    = m_total_reg;
        m_ovf_next      = m_ovf_reg;

        cnt_we      = 1'b0;
        cnt_waddr   = drop_slot_reg;
        cnt_wdata   = '0;
        cnt_raddr   = slot;
        hist_we     = 1'b0;
        hist_waddr  = right_reg[AW-1:0];
        hist_wdata  = slot;
        hist_raddr  = left_reg[AW-1:0];
        slot_ctrl.load    = 1'b0;
        slot_ctrl.advance = 1'b0;

        res_load  = 1'b0;
        res_total = total_reg;
        res_ovf   = 1'b0;

        budget_dec = budget_reg;
        left_plus  = left_reg + 1'b1;
        prefix_n   = prefix_reg;
        sum        = '0;
        drop       = 1'b0;

        if (cfg_valid)
        begin
            target_next = cfg_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    slot_ctrl.load = 1'b1;
                    first_next     = s_tuser[0];
                    state_next     = S_MOD;
                end
            end
            S_MOD:
            begin
                slot_ctrl.advance = 1'b1;
                if (first_reg)
                begin
                    dr_ptr_next  = left_reg;
                    dr_pend_next = 1'b0;
                    state_next   = S_DRAIN;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_DRAIN:
            begin
                // zero the count of every slot still in the window
                if (dr_pend_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = hist_rdata;
                end
                if (dr_ptr_reg < right_reg)
                begin
                    hist_raddr   = dr_ptr_reg[AW-1:0];
                    dr_ptr_next  = dr_ptr_reg + 1'b1;
                    dr_pend_next = 1'b1;
                end
                else
                begin
                    dr_pend_next = 1'b0;
                    if (!dr_pend_reg)
                    begin
                        left_next   = '0;
                        right_next  = '0;
                        budget_next = (target_reg == '0) ?
                                      BUDGET_W'(1) : $signed({1'b0, target_reg});
                        prefix_next = '0;
                        total_next  = '0;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (right_reg >= LEN_LIMIT)
                begin
                    res_load = 1'b1;
                    res_ovf  = 1'b1;
                end
                else
                begin
                    cnt_raddr  = slot;
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                cnt_we      = 1'b1;
                cnt_waddr   = slot;
                cnt_wdata   = cnt_rdata + 1'b1;
                hist_we     = 1'b1;
                right_next  = right_reg + 1'b1;
                budget_dec  = budget_reg - ((cnt_rdata == '0) ? BUDGET_W'(1) : BUDGET_W'(0));
                budget_next = budget_dec;
                // history read of the leftmost element starts here
                hist_raddr  = left_reg[AW-1:0];
                if (budget_dec[BUDGET_W-1])
                begin
                    trim_next  = 1'b0;
                    state_next = S_CREAD;
                end
                else if (budget_dec == '0)
                begin
                    trim_next  = 1'b1;
                    state_next = S_CREAD;
                end
                else
                begin
                    res_load = 1'b1;
                end
            end
            S_CREAD:
            begin
                cnt_raddr      = hist_rdata;
                drop_slot_next = hist_rdata;
                state_next     = S_DEC;
            end
            S_DEC:
            begin
                cnt_waddr = drop_slot_reg;
                if (!trim_reg)
                begin
                    // new distinct value pushed the budget negative
                    cnt_we      = 1'b1;
                    cnt_wdata   = cnt_rdata - CW'(cnt_rdata != '0);
                    left_next   = left_plus;
                    budget_next = budget_reg + BUDGET_W'(1);
                    prefix_n    = '0;
                    drop        = 1'b1;
                end
                else if (cnt_rdata > CW'(1))
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata - 1'b1;
                    left_next = left_plus;
                    prefix_n  = prefix_reg + 1'b1;
                    drop      = 1'b1;
                end
                prefix_next = prefix_n;
                trim_next   = 1'b1;
                if (drop && (left_plus < right_reg))
                begin
                    hist_raddr = left_plus[AW-1:0];
                    state_next = S_CREAD;
                end
                else
                begin
                    sum        = {1'b0, total_reg} + (TOTAL_W + 1)'(prefix_n) + 1'b1;
                    total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    res_total  = total_next;
                    res_load   = 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_total_next = pend_total_reg;
                    m_ovf_next   = pend_ovf_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            if (out_free)
            begin
                m_valid_next = 1'b1;
                m_total_next = res_total;
                m_ovf_next   = res_ovf;
                state_next   = S_IDLE;
            end
            else
            begin
                pend_total_next = res_total;
                pend_ovf_next   = res_ovf;
                state_next      = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            target_reg     <= TARGET_W'(1);
            first_reg      <= 1'b0;
            left_reg       <= '0;
            right_reg      <= '0;
            budget_reg     <= BUDGET_W'(1);
            prefix_reg     <= '0;
            total_reg      <= '0;
            dr_ptr_reg     <= '0;
            dr_pend_reg    <= 1'b0;
            trim_reg       <= 1'b0;
            drop_slot_reg  <= '0;
            pend_total_reg <= '0;
            pend_ovf_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_total_reg    <= '0;
            m_ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            target_reg     <= target_next;
            first_reg      <= first_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            budget_reg     <= budget_next;
            prefix_reg     <= prefix_next;
            total_reg      <= total_next;
            dr_ptr_reg     <= dr_ptr_next;
            dr_pend_reg    <= dr_pend_next;
            trim_reg       <= trim_next;
            drop_slot_reg  <= drop_slot_next;
            pend_total_reg <= pend_total_next;
            pend_ovf_reg   <= pend_ovf_next;
            m_valid_reg    <= m_valid_next;
            m_total_reg    <= m_total_next;
            m_ovf_reg      <= m_ovf_next;
        end
    end

endmodule
